>>> rtl/msp_pkg.sv
// ----------------------------------------------------------------------------
// msp_pkg: shared types for the MAC subheader parser
// Octet phase encoding and the packed result word.
// ----------------------------------------------------------------------------
package msp_pkg;

  localparam int unsigned LcidW  = 5;
  localparam int unsigned LenW   = 22;
  localparam int unsigned CountW = 16;

  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  // Which octet of the subheader is expected next
  typedef enum logic [1:0] {
    PH_LCID = 2'd0,
    PH_LEN1 = 2'd1,
    PH_LEN2 = 2'd2,
    PH_LEN3 = 2'd3
  } phase_t;

  typedef struct packed {
    logic [LcidW-1:0]  channel_id;
    logic [LenW-1:0]   payload_length;
    logic              last_subheader;
    logic [CountW-1:0] header_bytes;
  } result_t;

endpackage

>>> rtl/msp_decode.sv
// ----------------------------------------------------------------------------
// msp_decode: subheader octet decoder
// Holds the octet phase and partial fields; flags a completed subheader.
// ----------------------------------------------------------------------------
module msp_decode (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic [7:0]       data_byte,
  output logic             emit,
  output msp_pkg::result_t result
);
  import msp_pkg::*;

  phase_t            phase_r, phase_nxt;
  logic [LcidW-1:0]  chan_r, chan_nxt;
  logic [LenW-1:0]   len_r, len_nxt;
  logic              final_r, final_nxt;
  logic [CountW-1:0] count_r, count_nxt;
  logic [CountW-1:0] count_inc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_LCID;
      count_r <= '0;
      final_r <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
      final_r <= final_nxt;
    end
  end

  // partial fields: always written before they are read
  always_ff @(posedge clk) begin
    if (step) begin
      chan_r <= chan_nxt;
      len_r  <= len_nxt;
    end
  end

  assign count_inc = (count_r == CountMax) ? CountMax : count_r + CountW'(1);

  always_comb begin
    phase_nxt = phase_r;
    chan_nxt  = chan_r;
    len_nxt   = len_r;
    final_nxt = final_r;
    count_nxt = count_inc;
    emit      = 1'b0;
    unique case (phase_r)
      PH_LCID: begin
        chan_nxt  = data_byte[LcidW-1:0];
        final_nxt = (data_byte[7:5] == 3'b000);
        len_nxt   = '0;
        phase_nxt = PH_LEN1;
      end
      PH_LEN1: begin
        len_nxt = {15'd0, data_byte[6:0]};
        if (data_byte[7]) phase_nxt = PH_LEN2;
        else              emit      = 1'b1;
      end
      PH_LEN2: begin
        len_nxt = len_r | {8'd0, data_byte[6:0], 7'd0};
        if (data_byte[7]) phase_nxt = PH_LEN3;
        else              emit      = 1'b1;
      end
      PH_LEN3: begin
        len_nxt = len_r | {data_byte, 14'd0};
        emit    = 1'b1;
      end
      default: begin
        phase_nxt = PH_LCID;
      end
    endcase
    if (emit) begin
      phase_nxt = PH_LCID;
      if (final_r) count_nxt = '0;
    end
  end

  assign result.channel_id     = chan_r;
  assign result.payload_length = len_nxt;
  assign result.last_subheader = final_r;
  assign result.header_bytes   = count_inc;

endmodule

>>> rtl/msp_out_stage.sv
// ----------------------------------------------------------------------------
// msp_out_stage: result register
// One-entry output register; takes a new word while the old one drains.
// ----------------------------------------------------------------------------
module msp_out_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  msp_pkg::result_t load_word,
  output logic             can_take,
  output logic             out_valid,
  input  logic             out_ready,
  output msp_pkg::result_t out_word
);
  import msp_pkg::*;

  logic    valid_r, valid_nxt;
  result_t word_r;

  assign can_take  = !valid_r || out_ready;
  assign valid_nxt = load ? 1'b1 : (valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      word_r <= load_word;
    end
  end

  assign out_valid = valid_r;
  assign out_word  = word_r;

endmodule

>>> rtl/mac_subheader_parser.sv
// ----------------------------------------------------------------------------
// mac_subheader_parser: MAC PDU subheader decoder
// Byte-serial parser of R/R/E/LCID and F/L length octets.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready/in_data_byte) carries one header octet
//   per word. Result channel (out_*) carries one word per completed
//   subheader: LCID, 7/14/22-bit length, last flag and the running header
//   octet count (saturating at 65535, cleared after a last subheader).
//   Octets that do not complete a subheader produce no result.
// Latency: a result appears on out_valid the cycle after its final octet
//   is accepted.
// Throughput: one octet per cycle while in_ready is high, set by the single
//   decode step between the phase registers and the result register.
// Stall: while a result waits and out_ready is low, in_ready drops; it
//   rises again in the same cycle that out_ready returns (the result
//   register is refilled as it drains).
// Reset: rst_n (synchronous, active low) returns the parser to expecting
//   the first octet of a new header with a zero count and no result held.
// ----------------------------------------------------------------------------
module mac_subheader_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  out_channel_id,
  output logic [21:0] out_payload_length,
  output logic        out_last_subheader,
  output logic [15:0] out_header_bytes
);
  import msp_pkg::*;

  logic    in_fire;
  logic    dec_emit;
  logic    can_take;
  result_t dec_word;
  result_t out_word;

  // octet accepted whenever the result register has room
  assign in_ready = can_take;
  assign in_fire  = in_valid && in_ready;

  msp_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (in_fire),
    .data_byte (in_data_byte),
    .emit      (dec_emit),
    .result    (dec_word)
  );

  msp_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (in_fire && dec_emit),
    .load_word (dec_word),
    .can_take  (can_take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

  assign out_channel_id     = out_word.channel_id;
  assign out_payload_length = out_word.payload_length;
  assign out_last_subheader = out_word.last_subheader;
  assign out_header_bytes   = out_word.header_bytes;

  // every subheader is at least two octets
  a_min_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_header_bytes >= 16'd2))
    else $error("header byte count below two on a result");

  // a completed subheader always lands in the result register
  a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && dec_emit) |=> out_valid)
    else $error("completed subheader lost");

  // a held, stalled result must not be overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("input accepted while result stalled");

endmodule
